>>> rtl/core/keyed_top_k_board_defines.svh
// Assertion macros used by the leaderboard top level.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef KEYED_TOP_K_BOARD_DEFINES_SVH
`define KEYED_TOP_K_BOARD_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define KTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define KTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ktb_pkg.sv
// Shared types and codes for the keyed leaderboard.
// No dependencies; used by the board cell and the top level.
`timescale 1ns / 1ps

package ktb_pkg;

  typedef struct packed {
    logic [31:0] role;
    logic [31:0] user;
    logic [31:0] score;
  } entry_t;

  typedef struct packed {
    logic first_hit;
    logic blocked;
    logic at_ins;
    logic ge;
  } cell_stat_t;

  typedef struct packed {
    logic [2:0] kind;
    entry_t     ent;
  } result_t;

  localparam logic [1:0] OP_SUBMIT = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] KIND_FIRST   = 3'd0;
  localparam logic [2:0] KIND_EVICT   = 3'd1;
  localparam logic [2:0] KIND_TAKEN   = 3'd2;
  localparam logic [2:0] KIND_REFRESH = 3'd3;
  localparam logic [2:0] KIND_ENTRY   = 3'd4;
  localparam logic [2:0] KIND_EMPTY   = 3'd5;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_INSERT = 2'd2;

endpackage

>>> rtl/core/ktb_cell.sv
// One board position: holds an entry and shifts with its neighbors.
// Depends on ktb_pkg.
`timescale 1ns / 1ps

module ktb_cell (
  input  logic                clk_i,
  input  logic [1:0]          mode_i,
  input  logic                valid_i,
  input  ktb_pkg::entry_t     key_i,
  input  ktb_pkg::entry_t     left_i,
  input  ktb_pkg::entry_t     right_i,
  input  logic                hit_i,
  input  logic                ins_i,
  output ktb_pkg::entry_t     entry_o,
  output logic                hit_o,
  output logic                ins_o,
  output ktb_pkg::cell_stat_t stat_o
);

  ktb_pkg::entry_t entry_q, entry_d;
  logic match, ge, sel;

  assign match = valid_i && (entry_q.role == key_i.role);
  assign ge    = valid_i && (key_i.score >= entry_q.score);
  assign sel   = valid_i ? ge : 1'b1;
  assign hit_o = hit_i | match;
  assign ins_o = ins_i | sel;

  assign stat_o.first_hit = match && !hit_i;
  assign stat_o.blocked   = match && !hit_i && (key_i.score < entry_q.score);
  assign stat_o.at_ins    = sel && !ins_i;
  assign stat_o.ge        = ge;
  assign entry_o          = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (mode_i)
      ktb_pkg::MODE_REMOVE: begin
        if (hit_o) entry_d = right_i;
      end
      ktb_pkg::MODE_INSERT: begin
        if (ins_i) entry_d = left_i;
        else if (sel) entry_d = key_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> rtl/core/keyed_top_k_board.sv
// Top level of the keyed leaderboard: control, count and a row of board cells.
// Depends on ktb_pkg, ktb_cell and keyed_top_k_board_defines.svh.
//
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   op, role_id, user_id, score, position
//  out      output     out_valid_o / out_stall_i kind, other_role, other_user,
//                                                entry_score, last
//  config   input      max_entries_we_i          max_entries_i
//
// A read's result shows in the cycle after it is taken; after accept, a delete does
// duplicate removal, a load placement, a submit both in turn, each via the cell row.
// Results go one per cycle while unstalled; the next item is taken once all are gone.
// Reset clears the entry count and sets the limit to 32; cell contents need no reset.
// A stalled output holds its result and keeps the input stalled.
`timescale 1ns / 1ps
`include "keyed_top_k_board_defines.svh"

module keyed_top_k_board #(
  parameter int CAPACITY = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        max_entries_we_i,
  input  logic [5:0]  max_entries_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] role_id_i,
  input  logic [31:0] user_id_i,
  input  logic [31:0] score_i,
  input  logic [4:0]  position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] other_role_o,
  output logic [31:0] other_user_o,
  output logic [31:0] entry_score_o,
  output logic        last_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 5) ? CW : 5;
  localparam int LW = (CW > 6) ? CW : 6;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DEDUP = 2'd1;
  localparam logic [1:0] ST_PLACE = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [5:0]          max_q;
  logic [1:0]          op_q;
  ktb_pkg::entry_t     key_q;
  logic                self_led_q, self_led_d;
  ktb_pkg::result_t    res_q [2];
  ktb_pkg::result_t    res_d [2];
  logic [1:0]          res_cnt_q, res_cnt_d;
  logic                res_idx_q, res_idx_d;
  logic                load_key;
  logic [1:0]          mode;

  ktb_pkg::entry_t     entry_w [CAPACITY];
  ktb_pkg::cell_stat_t stat_w  [CAPACITY];
  logic [CAPACITY:0]   hit_w, ins_w;
  logic [CAPACITY-1:0] valid_w;

  logic                any_hit, blocked, any_ge, ins0, full, drop, rd_hit;
  logic [LW-1:0]       limit;
  ktb_pkg::entry_t     tail_e, read_e;

  assign hit_w[0] = 1'b0;
  assign ins_w[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ktb_pkg::entry_t left_e, right_e;
    assign valid_w[g] = CW'(g) < count_q;
    if (g == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_inner
      assign right_e = entry_w[g+1];
    end
    ktb_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (mode),
      .valid_i (valid_w[g]),
      .key_i   (key_q),
      .left_i  (left_e),
      .right_i (right_e),
      .hit_i   (hit_w[g]),
      .ins_i   (ins_w[g]),
      .entry_o (entry_w[g]),
      .hit_o   (hit_w[g+1]),
      .ins_o   (ins_w[g+1]),
      .stat_o  (stat_w[g])
    );
  end

  always_comb begin
    any_hit = 1'b0;
    blocked = 1'b0;
    any_ge  = 1'b0;
    tail_e  = '0;
    read_e  = '0;
    rd_hit  = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_hit = any_hit | stat_w[i].first_hit;
      blocked = blocked | stat_w[i].blocked;
      any_ge  = any_ge | stat_w[i].ge;
      if (valid_w[i] && ((i == CAPACITY - 1) || !valid_w[(i + 1) % CAPACITY])) begin
        tail_e = tail_e | entry_w[i];
      end
      if (valid_w[i] && (IW'(i) == IW'(position_i))) begin
        read_e = read_e | entry_w[i];
        rd_hit = 1'b1;
      end
    end
  end

  assign ins0  = stat_w[0].at_ins;
  assign limit = (max_q == 6'd0) ? LW'(1) :
                 ((LW'(max_q) > LW'(CAPACITY)) ? LW'(CAPACITY) : LW'(max_q));
  assign full  = LW'(count_q) >= limit;
  assign drop  = !any_ge && full;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    self_led_d = self_led_q;
    res_d      = res_q;
    res_cnt_d  = res_cnt_q;
    res_idx_d  = res_idx_q;
    load_key   = 1'b0;
    mode       = ktb_pkg::MODE_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_key  = 1'b1;
          res_idx_d = 1'b0;
          case (op_i)
            ktb_pkg::OP_READ: begin
              res_cnt_d = 2'd1;
              if (rd_hit) begin
                res_d[0] = '{kind: ktb_pkg::KIND_ENTRY, ent: read_e};
              end else begin
                res_d[0] = '{kind: ktb_pkg::KIND_EMPTY, ent: '0};
              end
              state_d = ST_OUT;
            end
            ktb_pkg::OP_LOAD: state_d = ST_PLACE;
            default:          state_d = ST_DEDUP;
          endcase
        end
      end
      ST_DEDUP: begin
        self_led_d = valid_w[0] && (entry_w[0].role == key_q.role);
        if ((op_q == ktb_pkg::OP_SUBMIT) && blocked) begin
          state_d = ST_IDLE;
        end else begin
          mode = ktb_pkg::MODE_REMOVE;
          if (any_hit) count_d = count_q - CW'(1);
          state_d = (op_q == ktb_pkg::OP_SUBMIT) ? ST_PLACE : ST_IDLE;
        end
      end
      ST_PLACE: begin
        res_cnt_d = 2'd0;
        if (!drop) begin
          mode = ktb_pkg::MODE_INSERT;
          if (!full) count_d = count_q + CW'(1);
        end
        if (op_q == ktb_pkg::OP_SUBMIT) begin
          if (count_q == '0) begin
            if (!self_led_q) begin
              res_d[0]  = '{kind: ktb_pkg::KIND_FIRST, ent: '0};
              res_cnt_d = 2'd1;
            end
          end else if (any_ge) begin
            if (full) begin
              res_d[0] = '{kind: ktb_pkg::KIND_EVICT,
                           ent: '{role: tail_e.role, user: tail_e.user, score: '0}};
              res_d[1] = '{kind: ktb_pkg::KIND_TAKEN,
                           ent: '{role: entry_w[0].role, user: entry_w[0].user, score: '0}};
              res_cnt_d = ins0 ? 2'd2 : 2'd1;
            end else if (ins0) begin
              res_d[0] = '{kind: self_led_q ? ktb_pkg::KIND_REFRESH : ktb_pkg::KIND_TAKEN,
                           ent: '{role: entry_w[0].role, user: entry_w[0].user, score: '0}};
              res_cnt_d = 2'd1;
            end
          end
        end
        state_d = (res_cnt_d != 2'd0) ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          if (2'(res_idx_q) + 2'd1 >= res_cnt_q) begin
            state_d = ST_IDLE;
          end else begin
            res_idx_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      max_q     <= 6'd32;
      res_cnt_q <= 2'd0;
      res_idx_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      res_cnt_q <= res_cnt_d;
      res_idx_q <= res_idx_d;
      if (max_entries_we_i) max_q <= max_entries_i;
    end
  end

  always_ff @(posedge clk_i) begin
    self_led_q <= self_led_d;
    res_q      <= res_d;
    if (load_key) begin
      op_q  <= op_i;
      key_q <= '{role: role_id_i, user: user_id_i, score: score_i};
    end
  end

  assign in_stall_o    = state_q != ST_IDLE;
  assign out_valid_o   = state_q == ST_OUT;
  assign kind_o        = res_q[res_idx_q].kind;
  assign other_role_o  = res_q[res_idx_q].ent.role;
  assign other_user_o  = res_q[res_idx_q].ent.user;
  assign entry_score_o = res_q[res_idx_q].ent.score;
  assign last_o        = (2'(res_idx_q) + 2'd1) == res_cnt_q;

  `KTB_ASSERT_NOW(a_count_cap, 1'b1, count_q <= CW'(CAPACITY), "entry count above capacity")
  `KTB_ASSERT_NOW(a_out_has_res, out_valid_o, res_cnt_q != 2'd0, "result offered with none queued")
  `KTB_ASSERT_NEXT(a_dedup_count, state_q == ST_DEDUP,
                   (count_q == $past(count_q)) || (count_q == $past(count_q) - CW'(1)),
                   "duplicate removal changed count by more than one")

endmodule
